// ===== design/page_frame_replacement_policy_macros.svh =====
// assertion macros for the page frame replacement policy block
// no dependencies; SYNTH removes the assertion bodies
`ifndef PAGE_FRAME_REPLACEMENT_POLICY_MACROS_SVH
`define PAGE_FRAME_REPLACEMENT_POLICY_MACROS_SVH
`ifndef SYNTH
`define PFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PFR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pfrp_pkg.sv =====
// shared types and constants of the page frame replacement policy block
// no dependencies
package pfrp_pkg;
    localparam int NumFramesDef = 16;
    localparam int PageBitsDef  = 24;
    localparam int StampBitsDef = 32;
    localparam int PageW  = 24;
    localparam int PinW   = 16;
    localparam int CntW   = 32;
    localparam int FrameW = 4;
    localparam int LimW   = 5;

    localparam logic [1:0] ModePin   = 2'd0;
    localparam logic [1:0] ModeUnpin = 2'd1;
    localparam logic [1:0] ModeDirty = 2'd2;
    localparam logic [1:0] ModeForce = 2'd3;

    localparam logic [1:0] PolFifo = 2'd0;
    localparam logic [1:0] PolLru  = 2'd1;
    localparam logic [1:0] PolLfu  = 2'd2;
    localparam logic [1:0] PolNone = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StNoVictim = 2'd1;
    localparam logic [1:0] StClean    = 2'd2;
    localparam logic [1:0] StPolicy   = 2'd3;

    localparam logic RegPolicy = 1'b0;
    localparam logic RegFrames = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_VRD   = 6'b001000,
        S_WR    = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;
endpackage

// ===== design/page_frame_replacement_policy.sv =====
// page frame replacement policy: frame table in one memory, scanned per request
// depends on pfrp_pkg and page_frame_replacement_policy_macros.svh
//
// channel  dir  handshake            payload
// input    in   i_valid / o_ready    i_mode, i_page_num
// output   out  o_valid / i_ready    o_status .. o_write_count
// config   in   i_cfg_we             i_cfg_index, i_cfg_wdata
//
// a request does one memory read per frame in use for the tag and victim scan,
// then a reread of the target frame, at most one write back and the result
// reset clears control and the per-frame valid bits at once; no clearing pass
// the next request is taken once the result register is free
`include "page_frame_replacement_policy_macros.svh"
module page_frame_replacement_policy
    import pfrp_pkg::*;
#(
    parameter int NUM_FRAMES = NumFramesDef,
    parameter int PAGE_BITS  = PageBitsDef,
    parameter int STAMP_BITS = StampBitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [LimW-1:0]   i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [PageW-1:0]  i_page_num,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic              o_hit,
    output logic [FrameW-1:0] o_frame,
    output logic              o_load_needed,
    output logic              o_writeback,
    output logic [PageW-1:0]  o_victim_page,
    output logic [PinW-1:0]   o_pin_count,
    output logic [CntW-1:0]   o_read_count,
    output logic [CntW-1:0]   o_write_count
);
    localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NumW = $clog2(NUM_FRAMES + 1);
    localparam logic [STAMP_BITS-1:0] StampMax = '1;

    typedef struct packed {
        logic                  dirty;
        logic [PAGE_BITS-1:0]  page;
        logic [PinW-1:0]       pins;
        logic [STAMP_BITS-1:0] lstamp;
        logic [STAMP_BITS-1:0] ustamp;
        logic [CntW-1:0]       uses;
    } t_entry;

    t_entry mem [NUM_FRAMES];
    t_entry r_rd;
    logic   [NUM_FRAMES-1:0] r_fvalid;

    t_state r_state;
    logic [1:0]            r_policy;
    logic [LimW-1:0]       r_frames;
    logic [1:0]            r_mode;
    logic [PAGE_BITS-1:0]  r_page;
    logic [IdxW-1:0]       r_addr;
    logic [NumW-1:0]       r_cnt;
    logic [NumW-1:0]       r_lim;
    logic                  r_rdv;
    logic [IdxW-1:0]       r_rdi;
    logic                  r_found;
    logic [IdxW-1:0]       r_fidx;
    logic                  r_empty;
    logic [IdxW-1:0]       r_eidx;
    logic                  r_vok;
    logic [IdxW-1:0]       r_vidx;
    logic [CntW-1:0]       r_vkey;
    logic [STAMP_BITS-1:0] r_vstamp;
    logic [STAMP_BITS-1:0] r_clock;
    logic [CntW-1:0]       r_reads;
    logic [CntW-1:0]       r_writes;
    logic                  r_we;
    logic [IdxW-1:0]       r_wa;
    t_entry                r_wd;
    logic                  r_wvalid;
    logic                  r_ovalid;

    // effective frame limit
    logic [NumW-1:0] lim;
    always_comb begin
        if (r_frames == '0) lim = NumW'(1);
        else if (32'(r_frames) > NUM_FRAMES) lim = NumW'(NUM_FRAMES);
        else lim = NumW'(r_frames);
    end

    logic [STAMP_BITS-1:0] key_stamp;
    logic                  better;
    always_comb begin
        key_stamp = (r_policy == PolFifo) ? r_rd.lstamp : r_rd.ustamp;
        if (r_policy == PolLfu) better = r_rd.uses < r_vkey;
        else better = key_stamp < r_vstamp;
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_read_count  = r_reads;
    assign o_write_count = r_writes;

    // memory: one write port, one registered read port
    logic          rd_en;
    logic [IdxW-1:0] rd_a;
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        if (rd_en) r_rd <= mem[rd_a];
    end

    function automatic logic [CntW-1:0] sat(input logic [CntW-1:0] v);
        return (v == '1) ? v : v + CntW'(1);
    endfunction

    logic [IdxW-1:0] tgt;
    always_comb begin
        rd_en = 1'b0;
        rd_a  = r_addr;
        tgt   = r_found ? r_fidx : (r_empty ? r_eidx : r_vidx);
        if (r_state == S_SCAN && r_cnt != r_lim) rd_en = 1'b1;
        if (r_state == S_DEC) begin
            rd_en = 1'b1;
            rd_a  = tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= PolFifo;
            r_frames <= LimW'(16);
            r_fvalid <= '0;
            r_clock  <= '0;
            r_reads  <= '0;
            r_writes <= '0;
            r_we     <= 1'b0;
            r_ovalid <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == RegPolicy) r_policy <= i_cfg_wdata[1:0];
                else r_frames <= i_cfg_wdata;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode  <= i_mode;
                        r_page  <= PAGE_BITS'(i_page_num);
                        r_addr  <= '0;
                        r_cnt   <= '0;
                        r_lim   <= lim;
                        r_rdv   <= 1'b0;
                        r_found <= 1'b0;
                        r_empty <= 1'b0;
                        r_vok   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // compare the frame read last cycle
                    if (r_rdv) begin
                        if (r_fvalid[r_rdi] && r_rd.page == r_page && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_rdi;
                        end
                        if (!r_fvalid[r_rdi] && !r_empty) begin
                            r_empty <= 1'b1;
                            r_eidx  <= r_rdi;
                        end
                        if (r_rd.pins == '0 && (!r_vok || better)) begin
                            r_vok    <= 1'b1;
                            r_vidx   <= r_rdi;
                            r_vkey   <= r_rd.uses;
                            r_vstamp <= key_stamp;
                        end
                    end
                    if (r_cnt != r_lim) begin
                        r_rdv  <= 1'b1;
                        r_rdi  <= r_addr;
                        r_addr <= r_addr + IdxW'(1);
                        r_cnt  <= r_cnt + NumW'(1);
                    end else begin
                        r_rdv   <= 1'b0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: r_state <= S_VRD;
                S_VRD: begin
                    // r_rd holds the target entry now
                    r_state       <= S_WR;
                    r_wa          <= tgt;
                    r_wd          <= r_rd;
                    o_status      <= StOk;
                    o_hit         <= r_found;
                    o_frame       <= r_found ? FrameW'(r_fidx) : '0;
                    o_load_needed <= 1'b0;
                    o_writeback   <= 1'b0;
                    o_victim_page <= '0;
                    o_pin_count   <= r_found ? r_rd.pins : '0;
                    r_wvalid      <= 1'b0;
                    if (r_mode == ModePin) begin
                        if (r_found) begin
                            r_we <= 1'b1;
                            r_wd.pins <= (r_rd.pins == '1) ? r_rd.pins
                                                            : r_rd.pins + PinW'(1);
                            o_pin_count <= (r_rd.pins == '1) ? r_rd.pins
                                                              : r_rd.pins + PinW'(1);
                            r_wd.uses <= sat(r_rd.uses);
                            r_wd.ustamp <= r_clock;
                            if (r_clock != StampMax) r_clock <= r_clock + 1'b1;
                        end else if (r_empty || (r_policy != PolNone && r_vok)) begin
                            if (!r_empty && r_fvalid[r_vidx] && r_rd.dirty) begin
                                o_writeback   <= 1'b1;
                                o_victim_page <= PageW'(r_rd.page);
                                r_writes      <= sat(r_writes);
                            end
                            r_we <= 1'b1;
                            r_wvalid <= 1'b1;
                            r_wd <= '{dirty: 1'b0, page: r_page, pins: PinW'(1),
                                      lstamp: r_clock, ustamp: r_clock,
                                      uses: CntW'(1)};
                            if (r_clock != StampMax) r_clock <= r_clock + 1'b1;
                            r_reads       <= sat(r_reads);
                            o_frame       <= FrameW'(tgt);
                            o_load_needed <= 1'b1;
                            o_pin_count   <= PinW'(1);
                        end else begin
                            o_status <= (r_policy == PolNone) ? StPolicy : StNoVictim;
                        end
                    end else if (r_found) begin
                        case (r_mode)
                            ModeUnpin: begin
                                if (r_rd.pins != '0) begin
                                    r_we <= 1'b1;
                                    r_wd.pins <= r_rd.pins - PinW'(1);
                                    o_pin_count <= r_rd.pins - PinW'(1);
                                end
                            end
                            ModeDirty: begin
                                r_we <= 1'b1;
                                r_wd.dirty <= 1'b1;
                            end
                            default: begin
                                if (r_rd.dirty) begin
                                    r_we <= 1'b1;
                                    r_wd.dirty    <= 1'b0;
                                    o_writeback   <= 1'b1;
                                    o_victim_page <= PageW'(r_rd.page);
                                    r_writes      <= sat(r_writes);
                                end else begin
                                    o_status <= StClean;
                                end
                            end
                        endcase
                    end
                end
                S_WR: begin
                    if (r_wvalid) r_fvalid[r_wa] <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PFR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `PFR_ASSERT_IMP(a_load_no_hit, i_clk, i_rst_n, o_valid && o_load_needed, !o_hit)
    `PFR_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    `PFR_ASSERT_IMP(a_busy_no_out, i_clk, i_rst_n, r_state == S_SCAN, !o_valid)
endmodule
